// ===== hdl/mlr_pkg.sv =====
`default_nettype none

package mlr_pkg;

   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS = 13;
   localparam int COLOR_BITS = 32;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int ACC_BITS = 2 * COORD_BITS + 4;
   localparam int EXT_BITS = COORD_BITS + SIZE_BITS;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1 << COORD_BITS);
   localparam logic [EXT_BITS-1:0] COORD_LIMIT = EXT_BITS'(1 << COORD_BITS);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_type;

   // largest usable coordinate for an image size register
   function automatic logic [COORD_BITS-1:0] axis_max(input logic [SIZE_BITS-1:0] size);
      logic [EXT_BITS-1:0] ext;
      logic [EXT_BITS-1:0] dec;
      ext = EXT_BITS'(size);
      dec = ext - EXT_BITS'(1);
      if (ext == '0) begin
         axis_max = '0;
      end else if (ext > COORD_LIMIT) begin
         axis_max = '1;
      end else begin
         axis_max = dec[COORD_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/midpoint_line_rasterizer_core.sv =====
// Midpoint line rasterizer core.
// Request channel (req_valid / req_stall): every accepted item is one tick.
// A tick with req_start_req set loads two endpoints and a color, drops any
// line in progress and produces the first pixel of the new line. Each later
// tick produces the next pixel until the one with rsp_last set; a tick while
// no line is active produces nothing.
// Result channel (rsp_valid / rsp_stall): one pixel item per producing tick,
// registered in the pixel register, or in the skid register while that is full.
// Throughput is one tick per cycle while req_stall is low: the decision term is
// updated by adds only, so the whole step fits between the line state registers
// and the pixel register. A two-entry output (pixel register plus skid register)
// keeps req_stall a registered signal; req_stall rises only when both hold a pixel.
// Image size registers are written through csr_write / csr_index / csr_wdata;
// the user must write them only while no line is active (the block does not enforce it).
// Reset (synchronous, active high) empties the output, ends any line and
// sets both image sizes to 4096.
`default_nettype none

module midpoint_line_rasterizer_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_start_req,
   input  wire  [mlr_pkg::COORD_BITS-1:0]   req_x0,
   input  wire  [mlr_pkg::COORD_BITS-1:0]   req_y0,
   input  wire  [mlr_pkg::COORD_BITS-1:0]   req_x1,
   input  wire  [mlr_pkg::COORD_BITS-1:0]   req_y1,
   input  wire  [mlr_pkg::COLOR_BITS-1:0]   req_line_color,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [mlr_pkg::COORD_BITS-1:0]   rsp_pixel_x,
   output logic [mlr_pkg::COORD_BITS-1:0]   rsp_pixel_y,
   output logic [mlr_pkg::COLOR_BITS-1:0]   rsp_pixel_color,
   output logic                             rsp_last,
   input  wire                              csr_write,
   input  wire  [mlr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [mlr_pkg::SIZE_BITS-1:0]    csr_wdata
);

   import mlr_pkg::*;

   logic [SIZE_BITS-1:0] width_ff, height_ff;

   logic                   busy_ff, busy_in;
   logic                   steep_ff, steep_in;
   logic                   up_ff, up_in;
   logic                   dn_ff, dn_in;
   logic [COORD_BITS-1:0]  cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]  cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]  end_ff, end_in;
   logic signed [ACC_BITS-1:0] a2_ff, a2_in;
   logic signed [ACC_BITS-1:0] b2_ff, b2_in;
   logic signed [ACC_BITS-1:0] dec_ff, dec_in;
   logic [COLOR_BITS-1:0]  color_ff, color_in;

   pixel_type out_ff, out_in;
   pixel_type skid_ff, skid_in;
   logic      out_valid_ff, out_valid_in;
   logic      skid_valid_ff, skid_valid_in;

   logic [COORD_BITS-1:0] mx, my;
   logic [COORD_BITS-1:0] ax, ay, bx, by, sx, sy, ex, ey;
   logic signed [DIFF_BITS-1:0] dx, dy, a_new, b_new;
   logic [DIFF_BITS-1:0] adx, ady;
   logic steep_new, swap;

   logic                   sel_steep, sel_up, sel_dn;
   logic [COORD_BITS-1:0]  sel_x, sel_y, sel_end;
   logic signed [ACC_BITS-1:0] sel_a2, sel_b2, sel_dec;
   logic [COLOR_BITS-1:0]  sel_color;
   logic active, last_now, inc, dcr, req_take, out_take, produce;

   assign req_take = req_valid && !req_stall;
   assign out_take = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_pixel_x = out_ff.x;
   assign rsp_pixel_y = out_ff.y;
   assign rsp_pixel_color = out_ff.color;
   assign rsp_last = out_ff.last;

   always_comb begin
      mx = axis_max(width_ff);
      my = axis_max(height_ff);

      // endpoints saturate to the image edge
      ax = (req_x0 > mx) ? mx : req_x0;
      ay = (req_y0 > my) ? my : req_y0;
      bx = (req_x1 > mx) ? mx : req_x1;
      by = (req_y1 > my) ? my : req_y1;
      dx = signed'({1'b0, bx}) - signed'({1'b0, ax});
      dy = signed'({1'b0, by}) - signed'({1'b0, ay});
      adx = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
      ady = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
      steep_new = ady > adx;
      swap = steep_new ? (ay > by) : (ax > bx);
      sx = swap ? bx : ax;
      sy = swap ? by : ay;
      ex = swap ? ax : bx;
      ey = swap ? ay : by;
      a_new = signed'({1'b0, sy}) - signed'({1'b0, ey});
      b_new = signed'({1'b0, ex}) - signed'({1'b0, sx});

      if (req_start_req) begin
         sel_steep = steep_new;
         sel_x = sx;
         sel_y = sy;
         sel_end = steep_new ? ey : ex;
         sel_up = steep_new ? (sx < ex) : (sy < ey);
         sel_dn = steep_new ? (sx > ex) : (sy > ey);
         sel_a2 = ACC_BITS'(a_new) <<< 1;
         sel_b2 = ACC_BITS'(b_new) <<< 1;
         // line passes through the start point, so only the midpoint offset remains
         sel_dec = steep_new ? (ACC_BITS'(a_new) + (ACC_BITS'(b_new) <<< 1))
                             : ((ACC_BITS'(a_new) <<< 1) + ACC_BITS'(b_new));
         sel_color = req_line_color;
      end else begin
         sel_steep = steep_ff;
         sel_x = cur_x_ff;
         sel_y = cur_y_ff;
         sel_end = end_ff;
         sel_up = up_ff;
         sel_dn = dn_ff;
         sel_a2 = a2_ff;
         sel_b2 = b2_ff;
         sel_dec = dec_ff;
         sel_color = color_ff;
      end

      active = req_start_req || busy_ff;
      last_now = sel_steep ? (sel_y == sel_end) : (sel_x == sel_end);

      steep_in = sel_steep;
      up_in = sel_up;
      dn_in = sel_dn;
      end_in = sel_end;
      a2_in = sel_a2;
      b2_in = sel_b2;
      color_in = sel_color;
      busy_in = active && !last_now;

      if (sel_steep) begin
         inc = sel_up && (sel_dec > 0) && (sel_x < mx);
         dcr = !inc && sel_dn && (sel_dec < 0) && (sel_x != '0);
         cur_x_in = inc ? sel_x + 1'b1 : (dcr ? sel_x - 1'b1 : sel_x);
         cur_y_in = sel_y + 1'b1;
         dec_in = sel_dec + sel_b2 + (inc ? sel_a2 : (dcr ? -sel_a2 : '0));
      end else begin
         inc = sel_up && (sel_dec < 0) && (sel_y < my);
         dcr = !inc && sel_dn && (sel_dec > 0) && (sel_y != '0);
         cur_y_in = inc ? sel_y + 1'b1 : (dcr ? sel_y - 1'b1 : sel_y);
         cur_x_in = sel_x + 1'b1;
         dec_in = sel_dec + sel_a2 + (inc ? sel_b2 : (dcr ? -sel_b2 : '0));
      end

      produce = req_take && active;

      // two-entry output: pixel register, then skid register
      out_in = out_ff;
      skid_in = skid_ff;
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_take) begin
         out_valid_in = 1'b0;
      end
      if (out_take && skid_valid_ff) begin
         out_in = skid_ff;
         out_valid_in = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (produce) begin
         if (!out_valid_in) begin
            out_in = '{x: sel_x, y: sel_y, color: sel_color, last: last_now};
            out_valid_in = 1'b1;
         end else begin
            skid_in = '{x: sel_x, y: sel_y, color: sel_color, last: last_now};
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: width_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req_take) begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && active) begin
         steep_ff <= steep_in;
         up_ff <= up_in;
         dn_ff <= dn_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         end_ff <= end_in;
         a2_ff <= a2_in;
         b2_ff <= b2_in;
         dec_ff <= dec_in;
         color_ff <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a pixel while the pixel register is empty");

   a_major_in_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !steep_ff) |-> (cur_x_ff <= end_ff))
      else $error("major x coordinate passed the line end");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (req_take && active && last_now) |=> (!busy_ff && rsp_valid))
      else $error("last pixel did not end the line");

   a_tick_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_start_req) |=> rsp_valid)
      else $error("start tick produced no pixel");

endmodule

`default_nettype wire

// ===== dv/mlr_pixel_checker.sv =====
`timescale 1ns / 1ps

module mlr_pixel_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_stall,
   input  wire                                req_start_req,
   input  wire  [mlr_pkg::COORD_BITS-1:0]     req_x0,
   input  wire  [mlr_pkg::COORD_BITS-1:0]     req_y0,
   input  wire  [mlr_pkg::COORD_BITS-1:0]     req_x1,
   input  wire  [mlr_pkg::COORD_BITS-1:0]     req_y1,
   input  wire  [mlr_pkg::COLOR_BITS-1:0]     req_line_color,
   input  wire                                rsp_valid,
   input  wire                                rsp_stall,
   input  wire  [mlr_pkg::COORD_BITS-1:0]     rsp_pixel_x,
   input  wire  [mlr_pkg::COORD_BITS-1:0]     rsp_pixel_y,
   input  wire  [mlr_pkg::COLOR_BITS-1:0]     rsp_pixel_color,
   input  wire                                rsp_last,
   input  wire                                csr_write,
   input  wire  [mlr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [mlr_pkg::SIZE_BITS-1:0]      csr_wdata,
   input  wire                                end_of_run,
   output int                                 mismatch_count,
   output int                                 pixels_pending,
   output int                                 pixels_checked,
   output logic                               line_active
);
   import mlr_pkg::*;

   logic [SIZE_BITS-1:0]  image_w;
   logic [SIZE_BITS-1:0]  image_h;
   logic                  drawing;
   logic                  steep;
   logic [COORD_BITS-1:0] cur_x;
   logic [COORD_BITS-1:0] cur_y;
   logic [COORD_BITS-1:0] from_x;
   logic [COORD_BITS-1:0] from_y;
   logic [COORD_BITS-1:0] to_x;
   logic [COORD_BITS-1:0] to_y;
   logic [COLOR_BITS-1:0] pen;
   pixel_type             expected_pixels[$];
   bit                    leftovers_checked = 1'b0;

   function automatic logic [COORD_BITS-1:0] coord_ceiling(input logic [SIZE_BITS-1:0] size);
      int unsigned n;
      n = size;
      if (n == 0) n = 1;
      if (n > (1 << COORD_BITS)) n = 1 << COORD_BITS;
      return COORD_BITS'(n - 1);
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [COORD_BITS-1:0] v,
                                                         input logic [COORD_BITS-1:0] hi);
      return (v > hi) ? hi : v;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned seen,
                                  input longint unsigned wanted);
      $display("%0t ns pixel %0d: %s is %0h, expected %0h",
               $time, pixels_checked, what, seen, wanted);
      mismatch_count++;
   endtask

   // one tick of the rasterizer: optional load, then at most one pixel
   task automatic rasterize_tick(input logic start,
                                 input logic [COORD_BITS-1:0] ax, ay, bx, by,
                                 input logic [COLOR_BITS-1:0] color,
                                 output bit made, output pixel_type pix);
      logic [COORD_BITS-1:0] xlim, ylim, px, py, qx, qy;
      longint                dx, dy, sx, sy, ex, ey, cx, cy, a, b, c2, f2;
      logic                  swap, at_end;
      xlim = coord_ceiling(image_w);
      ylim = coord_ceiling(image_h);
      made = 1'b0;
      pix = '0;
      if (start) begin
         px = clamp_coord(ax, xlim);
         py = clamp_coord(ay, ylim);
         qx = clamp_coord(bx, xlim);
         qy = clamp_coord(by, ylim);
         sx = px;
         sy = py;
         ex = qx;
         ey = qy;
         dx = (ex > sx) ? ex - sx : sx - ex;
         dy = (ey > sy) ? ey - sy : sy - ey;
         steep = dy > dx;
         swap = steep ? (py > qy) : (px > qx);
         if (swap) begin
            from_x = qx;
            from_y = qy;
            to_x = px;
            to_y = py;
         end else begin
            from_x = px;
            from_y = py;
            to_x = qx;
            to_y = qy;
         end
         cur_x = from_x;
         cur_y = from_y;
         pen = color;
         drawing = 1'b1;
      end
      if (drawing) begin
         at_end = steep ? (cur_y == to_y) : (cur_x == to_x);
         pix.x = cur_x;
         pix.y = cur_y;
         pix.color = pen;
         pix.last = at_end;
         made = 1'b1;
         if (at_end) begin
            drawing = 1'b0;
         end else begin
            sx = from_x;
            sy = from_y;
            ex = to_x;
            ey = to_y;
            cx = cur_x;
            cy = cur_y;
            a = sy - ey;
            b = ex - sx;
            c2 = 2 * (sx * ey - ex * sy);
            if (steep) begin
               // decision at the midpoint half a step right, one step up
               f2 = a * (2 * cx + 1) + b * (2 * cy + 2) + c2;
               if (sx < ex && f2 > 0 && cur_x < xlim) cur_x = cur_x + 1'b1;
               else if (sx > ex && f2 < 0 && cur_x > 0) cur_x = cur_x - 1'b1;
               cur_y = cur_y + 1'b1;
            end else begin
               f2 = a * (2 * cx + 2) + b * (2 * cy + 1) + c2;
               if (sy < ey && f2 < 0 && cur_y < ylim) cur_y = cur_y + 1'b1;
               else if (sy > ey && f2 > 0 && cur_y > 0) cur_y = cur_y - 1'b1;
               cur_x = cur_x + 1'b1;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      pixel_type want;
      pixel_type pix;
      bit        made;
      if (reset) begin
         image_w = SIZE_RESET;
         image_h = SIZE_RESET;
         drawing = 1'b0;
         steep = 1'b0;
         cur_x = '0;
         cur_y = '0;
         from_x = '0;
         from_y = '0;
         to_x = '0;
         to_y = '0;
         pen = '0;
         mismatch_count = 0;
         pixels_checked = 0;
         expected_pixels.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_IMAGE_WIDTH) image_w = csr_wdata;
            else if (csr_index == CSR_IMAGE_HEIGHT) image_h = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            rasterize_tick(req_start_req, req_x0, req_y0, req_x1, req_y1, req_line_color,
                           made, pix);
            if (made) expected_pixels.push_back(pix);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected pixel x", rsp_pixel_x, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_x !== want.x) report_mismatch("pixel_x", rsp_pixel_x, want.x);
               if (rsp_pixel_y !== want.y) report_mismatch("pixel_y", rsp_pixel_y, want.y);
               if (rsp_pixel_color !== want.color)
                  report_mismatch("pixel_color", rsp_pixel_color, want.color);
               if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
            end
            pixels_checked++;
         end
         if (end_of_run && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (expected_pixels.size() != 0)
               report_mismatch("pixels never produced", expected_pixels.size(), 0);
         end
      end
      pixels_pending <= expected_pixels.size();
      line_active <= drawing;
   end

endmodule

// ===== dv/tb_midpoint_line_rasterizer_core.sv =====
`timescale 1ns / 1ps

module tb_midpoint_line_rasterizer_core;
   import mlr_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_start_req = 1'b0;
   logic [COORD_BITS-1:0]     req_x0 = '0;
   logic [COORD_BITS-1:0]     req_y0 = '0;
   logic [COORD_BITS-1:0]     req_x1 = '0;
   logic [COORD_BITS-1:0]     req_y1 = '0;
   logic [COLOR_BITS-1:0]     req_line_color = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [COORD_BITS-1:0]     rsp_pixel_x;
   logic [COORD_BITS-1:0]     rsp_pixel_y;
   logic [COLOR_BITS-1:0]     rsp_pixel_color;
   logic                      rsp_last;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [SIZE_BITS-1:0]      csr_wdata = '0;
   logic                      end_of_run = 1'b0;
   int                        mismatch_count;
   int                        pixels_pending;
   int                        pixels_checked;
   logic                      line_active;

   int                        req_mode = 2;
   int                        rsp_mode = 2;
   int                        rsp_count = 0;
   int                        ticks_sent = 0;
   int                        lines_started = 0;
   int                        size_settings = 0;
   logic [SIZE_BITS-1:0]      image_w = SIZE_RESET;
   logic [SIZE_BITS-1:0]      image_h = SIZE_RESET;

   midpoint_line_rasterizer_core u_dut (.*);

   mlr_pixel_checker u_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("midpoint_line_rasterizer_core: mismatch");
      $finish;
   end

   // mode 0 never waits, mode 1 waits now and then, mode 2 draws a random wait for every item
   function automatic int draw_wait(input int mode);
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 13)) : 0;
         default: return int'($urandom_range(0, 13));
      endcase
   endfunction

   initial begin
      int gap;
      forever begin
         if (rsp_count % 64 == 0) rsp_mode = $urandom_range(0, 2);
         gap = draw_wait(rsp_mode);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || rsp_stall !== 1'b0);
         rsp_count++;
      end
   end

   task automatic send_item(input logic start, input logic [COORD_BITS-1:0] ax, ay, bx, by,
                            input logic [COLOR_BITS-1:0] color);
      int gap;
      if (ticks_sent % 64 == 0) req_mode = $urandom_range(0, 2);
      gap = draw_wait(req_mode);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_req <= start;
      req_x0 <= ax;
      req_y0 <= ay;
      req_x1 <= bx;
      req_y1 <= by;
      req_line_color <= color;
      do @(posedge clock); while (req_stall !== 1'b0);
      ticks_sent++;
      if (start) lines_started++;
   endtask

   task automatic send_plain();
      send_item(1'b0, COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
                COORD_BITS'($urandom), $urandom);
   endtask

   task automatic draw_line(input logic [COORD_BITS-1:0] ax, ay, bx, by,
                            input logic [COLOR_BITS-1:0] color);
      send_item(1'b1, ax, ay, bx, by, color);
      do send_plain(); while (line_active);
   endtask

   // end any line, then wait for every pixel to drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (line_active) send_plain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixels_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_sizes(input logic [SIZE_BITS-1:0] w, h);
      settle();
      csr_write <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      image_w = w;
      image_h = h;
      size_settings++;
   endtask

   function automatic logic [COORD_BITS-1:0] pick_coord(input logic [SIZE_BITS-1:0] size);
      int hi;
      hi = (size == 0) ? 0 : ((size > (1 << COORD_BITS)) ? (1 << COORD_BITS) - 1 : size - 1);
      case ($urandom_range(0, 9))
         0: return COORD_BITS'($urandom);
         1: return $urandom_range(0, 1) ? {COORD_BITS{1'b1}} : {COORD_BITS{1'b0}};
         2: return COORD_BITS'(hi);
         default: return COORD_BITS'($urandom_range(0, hi));
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] v,
                                                        input int reach);
      int t;
      t = v;
      t = t + int'($urandom_range(0, 2 * reach)) - reach;
      if (t < 0) t = 0;
      if (t > (1 << COORD_BITS) - 1) t = (1 << COORD_BITS) - 1;
      return COORD_BITS'(t);
   endfunction

   task automatic random_line();
      logic [COORD_BITS-1:0] ax, ay, bx, by;
      int                    style;
      ax = pick_coord(image_w);
      ay = pick_coord(image_h);
      style = $urandom_range(0, 49);
      if (style == 0) begin
         bx = pick_coord(image_w);
         by = pick_coord(image_h);
      end else begin
         bx = near_coord(ax, (style < 8) ? 2 : 30);
         by = near_coord(ay, (style < 8) ? 2 : 30);
      end
      send_item(1'b1, ax, ay, bx, by, $urandom);
      // most lines run to their last pixel, the rest may be cut off by the next start
      if ($urandom_range(0, 4) != 0 && (style != 0 || $urandom_range(0, 3) == 0)) begin
         do send_plain(); while (line_active);
      end else begin
         repeat ($urandom_range(0, 12)) send_plain();
      end
   endtask

   initial begin
      logic [SIZE_BITS-1:0] w, h;
      int                   phase_start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ticks with no line in progress
      send_item(1'b0, '1, '1, '1, '1, 32'hFFFF_FFFF);
      send_item(1'b0, '0, '0, '0, '0, 32'h0000_0000);
      draw_line(0, 0, 0, 0, 32'h0000_0000);
      draw_line(4095, 4095, 4095, 4095, 32'hFFFF_FFFF);
      draw_line(10, 20, 17, 23, 32'h1234_5678);
      draw_line(30, 5, 22, 9, 32'h89AB_CDEF);
      draw_line(5, 5, 7, 14, 32'hFF00_00FF);
      draw_line(40, 50, 37, 41, 32'h00FF_FF00);
      draw_line(0, 0, 5, 5, 32'hA5A5_A5A5);
      draw_line(5, 0, 0, 5, 32'h5A5A_5A5A);
      // midpoint lands exactly on the line
      draw_line(0, 0, 4, 2, 32'h0F0F_0F0F);
      draw_line(0, 4, 2, 0, 32'hF0F0_F0F0);
      draw_line(4090, 4095, 4095, 4095, 32'h0000_00FF);
      draw_line(4095, 4089, 4095, 4095, 32'hFF00_0000);
      // new start drops the line in progress
      send_item(1'b1, 100, 100, 130, 110, 32'h1111_1111);
      repeat (3) send_plain();
      draw_line(0, 4095, 6, 4093, 32'h2222_2222);
      // endpoints outside a small image
      program_sizes(8, 5);
      draw_line(4095, 0, 0, 4095, 32'h3333_3333);
      draw_line(3, 4095, 4095, 2, 32'h4444_4444);
      program_sizes(0, 13'h1FFF);
      draw_line(3, 40, 2000, 0, 32'h5555_5555);
      draw_line(4095, 4095, 0, 4095, 32'h6666_6666);
      program_sizes(4097, 1);
      draw_line(4095, 3, 4080, 2000, 32'h7777_7777);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin w = 4096; h = 4096; end
            1: begin w = 1; h = 4096; end
            2: begin w = 4096; h = 0; end
            3: begin w = 13'h1FFF; h = 4097; end
            4: begin w = 2; h = 3; end
            5: begin
               w = SIZE_BITS'($urandom_range(1, 64));
               h = SIZE_BITS'($urandom_range(1, 64));
            end
            6: begin
               w = SIZE_BITS'($urandom_range(1, 4096));
               h = SIZE_BITS'($urandom_range(1, 4096));
            end
            default: begin w = 4096; h = 4096; end
         endcase
         program_sizes(w, h);
         phase_start = ticks_sent;
         while (ticks_sent - phase_start < 200) begin
            if ($urandom_range(0, 11) == 0) repeat ($urandom_range(1, 3)) send_plain();
            else random_line();
         end
      end

      settle();
      end_of_run <= 1'b1;
      repeat (8) @(posedge clock);
      $display("run covered %0d ticks and %0d line starts; %0d pixels compared",
               ticks_sent, lines_started, pixels_checked);
      $display("image size was set %0d times, including 0, 1, 4096, 4097 and 8191",
               size_settings);
      if (mismatch_count == 0) begin
         $display("midpoint_line_rasterizer_core: match");
      end else begin
         $display("midpoint_line_rasterizer_core: mismatch");
      end
      $finish;
   end

endmodule
